// ===== rtl/srec_pkg.sv =====
`default_nettype none

package srec_pkg;

  // Largest record payload that the length byte can describe.
  localparam logic [7:0] MaxCount   = 8'd250;
  // Address field plus checksum byte, added to the payload count.
  localparam logic [7:0] LenExtra   = 8'd5;
  // Default depth of the request queue between front and back.
  localparam int         QueueDepth = 2;

  // Request kinds.
  localparam logic KindData = 1'b0;
  localparam logic KindTerm = 1'b1;

  // ASCII characters used in the record text.
  localparam logic [7:0] CharS    = 8'h53;
  localparam logic [7:0] Char3    = 8'h33;
  localparam logic [7:0] Char7    = 8'h37;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharA    = 8'h41;
  localparam logic [7:0] CharCr   = 8'h0D;
  localparam logic [7:0] CharLf   = 8'h0A;
  localparam logic [7:0] CharNul  = 8'h00;

  // One input request.
  typedef struct packed {
    logic        kind;
    logic [31:0] record_address;
    logic [7:0]  byte_count;
    logic [7:0]  data_byte;
  } srec_in_t;

  // One output character.
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
    logic       record_end;
    logic       bad_order;
  } srec_out_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic        reject;
    logic        hdr;
    logic        dat;
    logic        tail;
    logic [7:0]  type_char;
    logic [7:0]  len;
    logic [31:0] addr;
    logic [7:0]  data;
    logic [7:0]  chk;
  } srec_job_t;

  // Upper-case hex digit of a nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v > 4'd9) begin
      r = CharA + {4'd0, v} - 8'd10;
    end else begin
      r = CharZero + {4'd0, v};
    end
    return r;
  endfunction

  // Low byte of the sum of the four address bytes.
  function automatic logic [7:0] addr_sum(input logic [31:0] a);
    return a[31:24] + a[23:16] + a[15:8] + a[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/srec_front.sv =====
`default_nettype none

module srec_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  srec_pkg::srec_in_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output srec_pkg::srec_job_t q_job
);
  import srec_pkg::*;

  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic       open;
  logic [7:0] cnt_eff;
  logic [7:0] asum;
  logic [7:0] base_sum;
  logic [7:0] sum;
  logic [7:0] left;
  logic [7:0] left_dec;

  // A request is taken whenever the queue has room.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign open = (bytes_left_r != 8'd0);
  assign asum = addr_sum(in_data.record_address);

  // Clamp the byte count into the legal range.
  always_comb begin
    if (in_data.byte_count == 8'd0) begin
      cnt_eff = 8'd1;
    end else if (in_data.byte_count > MaxCount) begin
      cnt_eff = MaxCount;
    end else begin
      cnt_eff = in_data.byte_count;
    end
  end

  // Running checksum and remaining count for a data byte.
  assign base_sum = open ? running_sum_r : (cnt_eff + LenExtra + asum);
  assign sum      = base_sum + in_data.data_byte;
  assign left     = open ? bytes_left_r : cnt_eff;
  assign left_dec = left - 8'd1;

  // Classify the request and work out the record state after it.
  always_comb begin
    q_job           = '0;
    q_job.addr      = in_data.record_address;
    q_job.data      = in_data.data_byte;
    bytes_left_nxt  = bytes_left_r;
    running_sum_nxt = running_sum_r;
    if (in_data.kind == KindTerm) begin
      if (open) begin
        q_job.reject = 1'b1;
      end else begin
        q_job.hdr       = 1'b1;
        q_job.tail      = 1'b1;
        q_job.type_char = Char7;
        q_job.len       = LenExtra;
        q_job.chk       = ~(LenExtra + asum);
      end
    end else begin
      q_job.hdr       = !open;
      q_job.dat       = 1'b1;
      q_job.tail      = (left_dec == 8'd0);
      q_job.type_char = Char3;
      q_job.len       = cnt_eff + LenExtra;
      q_job.chk       = ~sum;
      bytes_left_nxt  = left_dec;
      running_sum_nxt = (left_dec == 8'd0) ? 8'd0 : sum;
    end
  end

  // Record state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r  <= 8'd0;
      running_sum_r <= 8'd0;
    end else if (q_push) begin
      bytes_left_r  <= bytes_left_nxt;
      running_sum_r <= running_sum_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srec_queue.sv =====
`default_nettype none

module srec_queue #(
  parameter int DEPTH = srec_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  srec_pkg::srec_job_t push_job,
  input  logic                pop,
  output srec_pkg::srec_job_t head_job,
  output logic                empty,
  output logic                full
);
  import srec_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  srec_job_t           slot_r [DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     count_r;
  logic                do_push, do_pop;

  assign empty    = (count_r == CntW'(0));
  assign full     = (count_r == CntW'(DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slot_r[rd_ptr_r];

  // Next slot index with wrap at the queue depth.
  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? PtrW'(0) : p + PtrW'(1);
  endfunction

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

  // Storage slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srec_back.sv =====
`default_nettype none

module srec_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  srec_pkg::srec_job_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output srec_pkg::srec_out_t out_data
);
  import srec_pkg::*;

  // Character positions within a record line.
  localparam logic [4:0] StepS        = 5'd0;
  localparam logic [4:0] StepType     = 5'd1;
  localparam logic [4:0] StepLenHi    = 5'd2;
  localparam logic [4:0] StepLenLo    = 5'd3;
  localparam logic [4:0] StepAddrLast = 5'd11;
  localparam logic [4:0] StepDatHi    = 5'd12;
  localparam logic [4:0] StepDatLo    = 5'd13;
  localparam logic [4:0] StepChkHi    = 5'd14;
  localparam logic [4:0] StepChkLo    = 5'd15;
  localparam logic [4:0] StepCr       = 5'd16;
  localparam logic [4:0] StepLf       = 5'd17;

  logic       busy_r;
  srec_job_t  job_r;
  logic [4:0] step_r, step_nxt, step_start;
  logic       out_valid_r;
  srec_out_t  out_r;
  logic       advance;
  logic       last;
  logic [2:0] nib_idx;
  logic [3:0] addr_nib;
  logic [7:0] char_val;
  srec_out_t  char_out;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The output register moves on when it is empty or being taken.
  assign advance = !out_valid_r || !out_stall;

  // Address digits, most significant first.
  assign nib_idx  = 3'(step_r - StepLenLo - 5'd1);
  assign addr_nib = job_r.addr[{~nib_idx, 2'b00} +: 4];

  // Character at the current position.
  always_comb begin
    unique case (step_r)
      StepS:     char_val = CharS;
      StepType:  char_val = job_r.type_char;
      StepLenHi: char_val = hex_digit(job_r.len[7:4]);
      StepLenLo: char_val = hex_digit(job_r.len[3:0]);
      StepDatHi: char_val = hex_digit(job_r.data[7:4]);
      StepDatLo: char_val = hex_digit(job_r.data[3:0]);
      StepChkHi: char_val = hex_digit(job_r.chk[7:4]);
      StepChkLo: char_val = hex_digit(job_r.chk[3:0]);
      StepCr:    char_val = CharCr;
      StepLf:    char_val = CharLf;
      default:   char_val = hex_digit(addr_nib);
    endcase
  end

  assign last = job_r.reject || (step_r == StepLf) || ((step_r == StepDatLo) && !job_r.tail);

  // Output character, or the rejection marker.
  always_comb begin
    char_out             = '0;
    char_out.last_of_run = last;
    if (job_r.reject) begin
      char_out.out_char  = CharNul;
      char_out.bad_order = 1'b1;
    end else begin
      char_out.out_char   = char_val;
      char_out.record_end = (step_r == StepLf);
    end
  end

  // Next position: the data digits are skipped when the request carries none.
  always_comb begin
    if (step_r == StepAddrLast) begin
      step_nxt = job_r.dat ? StepDatHi : StepChkHi;
    end else begin
      step_nxt = step_r + 5'd1;
    end
  end

  // First position of a new request.
  always_comb begin
    if (q_head.hdr) begin
      step_start = StepS;
    end else if (q_head.dat) begin
      step_start = StepDatHi;
    end else begin
      step_start = StepChkHi;
    end
  end

  // Load a request when idle, or as the current one hands out its last character.
  assign q_pop = !q_empty && (!busy_r || (advance && last));

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= StepS;
    end else begin
      if (advance) begin
        out_valid_r <= busy_r;
        if (busy_r) begin
          out_r <= char_out;
        end
      end
      if (q_pop) begin
        busy_r <= 1'b1;
        job_r  <= q_head;
        step_r <= step_start;
      end else if (advance && busy_r) begin
        if (last) begin
          busy_r <= 1'b0;
        end else begin
          step_r <= step_nxt;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srec_s3_record_encoder_core.sv =====
`default_nettype none

// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   srec_in_t   (one request)
// out_      output     out_valid/out_stall srec_out_t  (one ASCII character)
//
// Each request yields one character per cycle unless stalled: two for a mid-record
// byte, 18 for a byte that opens and closes a record, 16 for a termination, one NUL
// for a rejected one. The back-end sequencer that steps through the record line sets
// the rate. A QUEUE_DEPTH-entry request queue lets input keep arriving while output
// is stalled. Reset is synchronous and active low; no record is open after reset.
module srec_s3_record_encoder_core #(
  parameter int QUEUE_DEPTH = srec_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  srec_pkg::srec_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output srec_pkg::srec_out_t out_data
);
  import srec_pkg::*;

  logic      q_full, q_empty, q_push, q_pop;
  srec_job_t q_push_job, q_head;

  // Front end: accept and classify requests.
  srec_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_push_job)
  );

  // Request queue.
  srec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .head_job (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Back end: serialise characters.
  srec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // A record always closes on the final character of its request.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.record_end |-> out_data.last_of_run)
    else $error("record end without last_of_run");

  // The record end marker sits only on a line feed.
  a_end_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.record_end |-> out_data.out_char == CharLf)
    else $error("record end on a character other than line feed");

  // A rejection is a single NUL character.
  a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_order |->
      out_data.last_of_run && out_data.out_char == CharNul && !out_data.record_end)
    else $error("malformed rejection character");
`endif

endmodule

`default_nettype wire
